FILE: hdl/nau_pkg.sv
`timescale 1ns / 1ps
// nau_pkg: shared types, mode codes and Q30 constants for the activation unit.
// No dependencies; imported by every nau_* module and the core.
package nau_pkg;

  // Payload of one item on each channel
  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] activated;
    logic               last_out;
  } out_item_t;

  // Sideband that travels alongside the exp/divide datapath
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [3:0]         mode;
    logic               neg;     // sample < 0
    logic signed [31:0] simple;  // result of the piecewise-linear modes, saturated
  } tag_t;

  // Activation modes
  localparam logic [3:0] MODE_LINEAR   = 4'd0;
  localparam logic [3:0] MODE_LOGISTIC = 4'd1;
  localparam logic [3:0] MODE_LOGGY    = 4'd2;
  localparam logic [3:0] MODE_RELU     = 4'd3;
  localparam logic [3:0] MODE_ELU      = 4'd4;
  localparam logic [3:0] MODE_SELU     = 4'd5;
  localparam logic [3:0] MODE_RELIE    = 4'd6;
  localparam logic [3:0] MODE_RAMP     = 4'd7;
  localparam logic [3:0] MODE_LEAKY    = 4'd8;
  localparam logic [3:0] MODE_TANH     = 4'd9;
  localparam logic [3:0] MODE_PLSE     = 4'd10;
  localparam logic [3:0] MODE_STAIR    = 4'd11;
  localparam logic [3:0] MODE_HARDTAN  = 4'd12;
  localparam logic [3:0] MODE_LHTAN    = 4'd13;

  // Register map
  localparam logic [2:0] ADDR_MODE = 3'd0;

  // Q30 constants
  localparam logic [30:0] Q30_ONE   = 31'd1073741824;
  localparam logic [30:0] C_P01     = 31'd10737418;
  localparam logic [30:0] C_P1      = 31'd107374182;
  localparam logic [30:0] C_P001    = 31'd1073742;
  localparam logic [30:0] C_P125    = 31'd134217728;
  localparam logic [30:0] C_LAMBDA  = 31'd1128180534;
  localparam logic [30:0] C_LAMALPH = 31'd1887671670;
  localparam logic [30:0] C_LOG2E   = 31'd1549082005;
  localparam logic [30:0] C_LN2     = 31'd744261118;

endpackage

FILE: hdl/nau_front.sv
`timescale 1ns / 1ps
// nau_front: three-stage front end. Piecewise-linear modes, exp argument
// reduction (t*log2e, f*ln2). Depends on nau_pkg.
module nau_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic               in_last,
  input  logic [3:0]         in_mode,
  input  logic signed [31:0] in_x,
  output logic [29:0]        y,
  output logic [5:0]         k,
  output logic               zero,
  output nau_pkg::tag_t      tag
);
  import nau_pkg::*;

  localparam logic [32:0]        T_LIMIT = 33'(32) << FRAC_BITS;
  localparam int                 SH24    = 24 - FRAC_BITS;
  localparam logic signed [33:0] ONE34   = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] FOUR34  = 34'sd4 <<< FRAC_BITS;
  localparam logic signed [35:0] ONE36   = 36'sd1 <<< FRAC_BITS;
  localparam logic signed [35:0] FOUR36  = 36'sd4 <<< FRAC_BITS;
  localparam logic signed [35:0] HALF36  = 36'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [35:0] FMASK   = (36'sd1 <<< FRAC_BITS) - 36'sd1;
  localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
  localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

  // stage 0 (combinational)
  logic [31:0]        ax;
  logic [32:0]        tw;
  logic [32:0]        tsh;
  logic signed [33:0] xe;
  logic signed [33:0] v;
  logic [30:0]        c;

  always_comb begin
    ax  = in_x[31] ? 32'(-in_x) : 32'(in_x);
    tw  = (in_mode == MODE_TANH) ? {ax, 1'b0} : {1'b0, ax};
    tsh = tw << SH24;
    xe  = 34'(in_x);
    v   = xe;
    c   = '0;
    case (in_mode)
      MODE_RELIE: c = C_P01;
      MODE_RAMP, MODE_LEAKY: c = C_P1;
      MODE_SELU: c = C_LAMBDA;
      MODE_PLSE: begin
        if (xe < -FOUR34) begin
          v = xe + FOUR34;
          c = C_P01;
        end else if (xe > FOUR34) begin
          v = xe - FOUR34;
          c = C_P01;
        end else begin
          c = C_P125;
        end
      end
      MODE_LHTAN: begin
        c = C_P001;
        if (xe > ONE34) v = xe - ONE34;
      end
      default: c = '0;
    endcase
  end

  // stage 1
  logic               s1_valid, s1_last, s1_vneg, s1_zero;
  logic [3:0]         s1_mode;
  logic signed [31:0] s1_x;
  logic [32:0]        s1_mv;
  logic [30:0]        s1_c;
  logic [28:0]        s1_t24;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s1_last  <= in_last;
      s1_mode  <= in_mode;
      s1_x     <= in_x;
      s1_vneg  <= v[33];
      s1_mv    <= v[33] ? 33'(-v) : 33'(v);
      s1_c     <= c;
      s1_t24   <= tsh[28:0];
      s1_zero  <= (tw >= T_LIMIT);
    end
  end

  // stage 2: constant multiply and t*log2e
  logic [63:0] pm;
  logic [59:0] pu;
  assign pm = 64'(s1_mv) * 64'(s1_c);
  assign pu = 60'(s1_t24) * 60'(C_LOG2E);

  logic               s2_valid, s2_last, s2_vneg, s2_zero;
  logic [3:0]         s2_mode;
  logic signed [31:0] s2_x;
  logic [33:0]        s2_m;
  logic [29:0]        s2_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      s2_last  <= s1_last;
      s2_mode  <= s1_mode;
      s2_x     <= s1_x;
      s2_vneg  <= s1_vneg;
      s2_zero  <= s1_zero;
      s2_m     <= pm[63:30];
      s2_u     <= pu[59:30];
    end
  end

  // stage 3: piecewise-linear result, f*ln2
  logic signed [35:0] mc, xe36, hone, fr, r, rs;
  logic signed [31:0] nfl, hh;
  logic [53:0]        pf;

  always_comb begin
    mc   = s2_vneg ? -$signed(36'(s2_m)) : $signed(36'(s2_m));
    xe36 = 36'(s2_x);
    nfl  = s2_x >>> FRAC_BITS;
    hh   = nfl >>> 1;
    hone = 36'(hh) <<< FRAC_BITS;
    fr   = xe36 & FMASK;
    case (s2_mode)
      MODE_LINEAR, MODE_ELU: r = xe36;
      MODE_RELU:             r = (xe36 > 0) ? xe36 : '0;
      MODE_SELU:             r = mc;
      MODE_RELIE, MODE_LEAKY: r = (xe36 > 0) ? xe36 : mc;
      MODE_RAMP:             r = ((xe36 > 0) ? xe36 : 36'sd0) + mc;
      MODE_PLSE: begin
        if (xe36 < -FOUR36)     r = mc;
        else if (xe36 > FOUR36) r = mc + ONE36;
        else                    r = mc + HALF36;
      end
      MODE_STAIR:            r = nfl[0] ? hone + fr : hone;
      MODE_HARDTAN: begin
        if (xe36 < -ONE36)     r = -ONE36;
        else if (xe36 > ONE36) r = ONE36;
        else                   r = xe36;
      end
      MODE_LHTAN: begin
        if (xe36 < 0)          r = mc;
        else if (xe36 > ONE36) r = mc + ONE36;
        else                   r = xe36;
      end
      default:               r = '0;
    endcase
    if (r > SAT_MAX)      rs = SAT_MAX;
    else if (r < SAT_MIN) rs = SAT_MIN;
    else                  rs = r;
  end

  assign pf = 54'(s2_u[23:0]) * 54'(C_LN2);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (en) begin
      tag.valid  <= s2_valid;
      tag.last   <= s2_last;
      tag.mode   <= s2_mode;
      tag.neg    <= s2_x[31];
      tag.simple <= rs[31:0];
      y          <= pf[53:24];
      k          <= s2_u[29:24];
      zero       <= s2_zero;
    end
  end

endmodule

FILE: hdl/nau_exp.sv
`timescale 1ns / 1ps
// nau_exp: pipelined Horner evaluation of exp(-t) in Q30, three stages per
// term (multiply, reciprocal multiply, correct), then the 2^-k shift. Uses nau_pkg.
module nau_exp (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [29:0]   y,
  input  logic [5:0]    k,
  input  logic          zero,
  input  nau_pkg::tag_t tag_in,
  output logic [30:0]   e,
  output nau_pkg::tag_t tag_out
);
  import nau_pkg::*;

  localparam int ITERS = 10;

  logic [29:0] ch_y   [0:ITERS];
  logic [5:0]  ch_k   [0:ITERS];
  logic        ch_z   [0:ITERS];
  tag_t        ch_tag [0:ITERS];
  logic [30:0] ch_acc [0:ITERS];

  assign ch_y[0]   = y;
  assign ch_k[0]   = k;
  assign ch_z[0]   = zero;
  assign ch_tag[0] = tag_in;
  assign ch_acc[0] = Q30_ONE;

  for (genvar i = 0; i < ITERS; i++) begin : g_term
    localparam int          DIV   = ITERS - i;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DIV);

    logic [29:0] a_y, b_y;
    logic [5:0]  a_k, b_k, c_k;
    logic        a_z, b_z, c_z;
    tag_t        a_tag, b_tag, c_tag;
    logic [30:0] a_q, b_q, b_est, c_acc;
    logic [29:0] c_y;
    logic [60:0] pa;
    logic [63:0] pb;
    logic [34:0] rr;
    logic [30:0] qd;

    assign pa = 61'(ch_y[i]) * 61'(ch_acc[i]);
    assign pb = 64'(a_q) * 64'(RECIP);
    assign rr = 35'(b_q) - 35'(b_est) * 35'(DIV);
    assign qd = (rr >= 35'(DIV)) ? b_est + 31'd1 : b_est;

    always_ff @(posedge clk) begin
      if (rst) begin
        a_tag.valid <= 1'b0;
        b_tag.valid <= 1'b0;
        c_tag.valid <= 1'b0;
      end else if (en) begin
        a_tag <= ch_tag[i];
        a_y   <= ch_y[i];
        a_k   <= ch_k[i];
        a_z   <= ch_z[i];
        a_q   <= pa[60:30];
        b_tag <= a_tag;
        b_y   <= a_y;
        b_k   <= a_k;
        b_z   <= a_z;
        b_q   <= a_q;
        b_est <= pb[62:32];
        c_tag <= b_tag;
        c_y   <= b_y;
        c_k   <= b_k;
        c_z   <= b_z;
        c_acc <= Q30_ONE - qd;
      end
    end

    assign ch_y[i+1]   = c_y;
    assign ch_k[i+1]   = c_k;
    assign ch_z[i+1]   = c_z;
    assign ch_tag[i+1] = c_tag;
    assign ch_acc[i+1] = c_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else if (en) begin
      tag_out <= ch_tag[ITERS];
      e       <= (ch_z[ITERS] || ch_k[ITERS] >= 6'd31) ? '0 : ch_acc[ITERS] >> ch_k[ITERS];
    end
  end

endmodule

FILE: hdl/nau_div.sv
`timescale 1ns / 1ps
// nau_div: ratio stage. Forms numerator/divisor from exp, runs a restoring
// divider two quotient bits per stage, and the elu/selu magnitudes. Uses nau_pkg.
module nau_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [30:0]          e,
  input  nau_pkg::tag_t        tag_in,
  output logic [FRAC_BITS:0]   quo,
  output logic [31:0]          alt,
  output nau_pkg::tag_t        tag_out
);
  import nau_pkg::*;

  localparam int NSTEP = FRAC_BITS + 1;
  localparam int NSTG  = (NSTEP + 1) / 2;
  localparam int QW    = FRAC_BITS + 1;

  // prep stage
  logic [30:0] om;
  logic [61:0] sp;
  logic [31:0] num;

  always_comb begin
    om = Q30_ONE - e;
    sp = 62'(om) * 62'(C_LAMALPH);
    if (tag_in.mode == MODE_LOGISTIC) num = tag_in.neg ? 32'(e) : 32'(Q30_ONE);
    else                              num = 32'(om);
  end

  logic [31:0] p_a, p_d;
  logic [30:0] p_om;
  logic [61:0] p_sp;
  tag_t        p_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_tag.valid <= 1'b0;
    end else if (en) begin
      p_tag <= tag_in;
      p_a   <= num;
      p_d   <= 32'(Q30_ONE) + 32'(e);
      p_om  <= om;
      p_sp  <= sp;
    end
  end

  logic [31:0]   ch_r   [0:NSTG];
  logic [31:0]   ch_d   [0:NSTG];
  logic [QW-1:0] ch_q   [0:NSTG];
  logic [31:0]   ch_alt [0:NSTG];
  tag_t          ch_tag [0:NSTG];

  assign ch_r[0]   = p_a;
  assign ch_d[0]   = p_d;
  assign ch_q[0]   = '0;
  assign ch_tag[0] = p_tag;
  assign ch_alt[0] = (p_tag.mode == MODE_SELU) ? 32'(p_sp >> (60 - FRAC_BITS))
                                               : 32'(p_om >> (30 - FRAC_BITS));

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [31:0]   r_n;
    logic [QW-1:0] q_n;
    logic [31:0]   st_r, st_d, st_alt;
    logic [QW-1:0] st_q;
    tag_t          st_tag;

    always_comb begin
      r_n = ch_r[s];
      q_n = ch_q[s];
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < NSTEP) begin
          if (2 * s + j > 0) r_n = r_n << 1;
          if (r_n >= ch_d[s]) begin
            r_n = r_n - ch_d[s];
            q_n = {q_n[QW-2:0], 1'b1};
          end else begin
            q_n = {q_n[QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_tag.valid <= 1'b0;
      end else if (en) begin
        st_tag <= ch_tag[s];
        st_r   <= r_n;
        st_q   <= q_n;
        st_d   <= ch_d[s];
        st_alt <= ch_alt[s];
      end
    end

    assign ch_r[s+1]   = st_r;
    assign ch_d[s+1]   = st_d;
    assign ch_q[s+1]   = st_q;
    assign ch_alt[s+1] = st_alt;
    assign ch_tag[s+1] = st_tag;
  end

  assign quo     = ch_q[NSTG];
  assign alt     = ch_alt[NSTG];
  assign tag_out = ch_tag[NSTG];

endmodule

FILE: hdl/neural_activation_unit_core.sv
`timescale 1ns / 1ps
// neural_activation_unit_core: top level of the activation unit.
// Instantiates nau_front, nau_exp and nau_div; uses nau_pkg.
//
// Streaming activation unit: each sample item (signed fixed point with
// FRAC_BITS fraction bits, Q15.16 by default) yields one activated item with
// last copied through. The function comes from the activation_mode register
// at byte address 0 of the APB port (0 linear, 1 logistic, 2 loggy, 3 relu,
// 4 elu, 5 selu, 6 relie, 7 ramp, 8 leaky, 9 tanh, 10 plse, 11 stair,
// 12 hardtan, 13 lhtan; 14 and 15 give 0); write it only while the unit is
// drained. One item is accepted per clock while sample_stall is low. Every
// item runs through the same fixed pipeline whatever the mode: 3 front
// stages, 31 exp stages (ten Horner terms of three stages plus the 2^-k
// shift), 1 + ceil((FRAC_BITS+1)/2) divider stages and the output register.
// The pipeline advances whenever the output register is empty or taken; a
// one-item skid register at the input holds a sample that arrives as the
// pipeline stalls, so sample_stall is a register output.
module neural_activation_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // sample channel
  input  logic                sample_valid,
  output logic                sample_stall,
  input  nau_pkg::in_item_t   sample_item,
  // result channel
  output logic                result_valid,
  input  logic                result_stall,
  output nau_pkg::out_item_t  result_item
);
  import nau_pkg::*;

  localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;

  // mode register
  logic [3:0] mode;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MODE) ? {28'b0, mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_LINEAR;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MODE) begin
      mode <= pwdata[3:0];
    end
  end

  // global advance: the whole pipeline moves unless the output item is held
  logic en;
  assign en = !(result_valid && result_stall);

  // input skid register
  logic      skid_full;
  in_item_t  skid_item;
  logic      ent_valid;
  in_item_t  ent_item;

  assign sample_stall = skid_full;
  assign ent_valid    = skid_full || sample_valid;
  assign ent_item     = skid_full ? skid_item : sample_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (en) begin
      skid_full <= 1'b0;
    end else if (sample_valid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && !skid_full) skid_item <= sample_item;
  end

  // datapath
  logic [29:0]        fr_y;
  logic [5:0]         fr_k;
  logic               fr_zero;
  tag_t               fr_tag;
  logic [30:0]        ex_e;
  tag_t               ex_tag;
  logic [FRAC_BITS:0] dv_quo;
  logic [31:0]        dv_alt;
  tag_t               dv_tag;

  nau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (ent_valid),
    .in_last  (ent_item.last),
    .in_mode  (mode),
    .in_x     (ent_item.sample),
    .y        (fr_y),
    .k        (fr_k),
    .zero     (fr_zero),
    .tag      (fr_tag)
  );

  nau_exp u_exp (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .y       (fr_y),
    .k       (fr_k),
    .zero    (fr_zero),
    .tag_in  (fr_tag),
    .e       (ex_e),
    .tag_out (ex_tag)
  );

  nau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .e       (ex_e),
    .tag_in  (ex_tag),
    .quo     (dv_quo),
    .alt     (dv_alt),
    .tag_out (dv_tag)
  );

  // final select: ratio modes use the quotient, elu/selu below zero use the
  // negated magnitude, everything else was settled in the front end
  logic signed [31:0] qs, res;
  logic [3:0]         res_mode;

  always_comb begin
    qs = $signed(32'(dv_quo));
    case (dv_tag.mode)
      MODE_LOGISTIC:         res = qs;
      MODE_LOGGY, MODE_TANH: res = dv_tag.neg ? -qs : qs;
      MODE_ELU, MODE_SELU:   res = dv_tag.neg ? -$signed(dv_alt) : dv_tag.simple;
      default:               res = dv_tag.simple;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid         <= dv_tag.valid;
      result_item.activated <= res;
      result_item.last_out  <= dv_tag.last;
      res_mode             <= dv_tag.mode;
    end
  end

`ifndef NO_ASSERTIONS
  // a held skid item stays put while the output is stalled
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_full && result_valid && result_stall) |=> skid_full)
    else $error("skid item dropped during stall");

  // the skid only fills when a sample arrives into a stalled pipeline
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(sample_valid && result_valid && result_stall))
    else $error("skid filled without a stalled arrival");

  // logistic output lies in [0, 1]
  a_logistic_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && res_mode == MODE_LOGISTIC) |->
      (result_item.activated >= 0 && result_item.activated <= ONE32))
    else $error("logistic result out of range");
`endif

endmodule
